// File: hw/rtl/gradient_noise_2d_unit_defines.svh
// Assertion macros for the gradient noise RTL (used by gn2d_back).
// Each expects clk and arst_n in scope.
`ifndef GRADIENT_NOISE_2D_UNIT_DEFINES_SVH
`define GRADIENT_NOISE_2D_UNIT_DEFINES_SVH

// same-cycle implication
`define GN2D_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gn2d assertion failed");

// next-cycle implication
`define GN2D_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gn2d assertion failed");

`endif

// File: hw/rtl/gn2d_pkg.sv
package gn2d_pkg;

	localparam int TABLE_SIZE = 256;
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	localparam logic [1:0] ADDR_COORD_SCALE = 2'd0;
	localparam logic [23:0] COORD_SCALE_RESET = 24'd65536;

	typedef struct packed {
		logic               ev;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [7:0]         idx;
		logic [7:0]         val;
	} gn2d_item_t;

	typedef logic [TABLE_SIZE-1:0][31:0] grad_rom_t;

	// Unit vector (sin, cos) at phase/2^32 of a turn, Q1.15; gx low half, gy high half.
	function automatic logic [31:0] make_unit(logic [31:0] phase);
		logic [63:0] t, t2, a, b, c, d, s, e, f, g, h, x, co, qs, qc;
		logic [15:0] sq, cq, gx, gy;
		t = ({34'd0, phase[29:0]} * HALF_PI_Q30) >> 30;
		t2 = (t * t) >> 30;
		a = Q30_ONE - t2 / 72;
		b = Q30_ONE - ((t2 * a) >> 30) / 42;
		c = Q30_ONE - ((t2 * b) >> 30) / 20;
		d = Q30_ONE - ((t2 * c) >> 30) / 6;
		s = (t * d) >> 30;
		e = Q30_ONE - t2 / 90;
		f = Q30_ONE - ((t2 * e) >> 30) / 56;
		g = Q30_ONE - ((t2 * f) >> 30) / 30;
		h = Q30_ONE - ((t2 * g) >> 30) / 12;
		x = ((t2 * h) >> 30) / 2;
		co = (x > Q30_ONE) ? 64'd0 : Q30_ONE - x;
		qs = (s + 64'd16384) >> 15;
		qc = (co + 64'd16384) >> 15;
		sq = (qs > 64'd32767) ? 16'd32767 : qs[15:0];
		cq = (qc > 64'd32767) ? 16'd32767 : qc[15:0];
		unique case (phase[31:30])
			2'd0: begin gx = sq; gy = cq; end
			2'd1: begin gx = cq; gy = 16'(-sq); end
			2'd2: begin gx = 16'(-sq); gy = 16'(-cq); end
			default: begin gx = 16'(-cq); gy = sq; end
		endcase
		return {gy, gx};
	endfunction

	function automatic grad_rom_t build_grad_rom();
		grad_rom_t rom;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			rom[i] = make_unit(32'((64'(i) << 32) / TABLE_SIZE));
		end
		return rom;
	endfunction

	localparam grad_rom_t GRAD_ROM = build_grad_rom();

endpackage

// File: hw/rtl/gradient_noise_2d_unit.sv
// Channel   Dir  Beat contents
// s_axis    in   tuser[0]=action; tdata: point_x, point_y, entry_index, entry_value
// m_axis    out  tdata: noise_value (evaluate beats only)
// apb       in   register 0 at address 0: coord_scale
//
// One input beat per clock while s_axis_tready is high; an evaluate result passes
// from its queue slot into s1, then through s2 to s7 and the output register. The
// back pipeline holds as a whole while m_axis stalls; the 2-entry queue then fills
// and drops s_axis_tready until the back end moves again.
// Reset clears the queue, the stage valid bits and coord_scale (1.0); the
// permutation table is not cleared and must be loaded before it is used.
module gradient_noise_2d_unit import gn2d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] point_x, [63:32] point_y, [71:64] entry_index, [79:72] entry_value
	input  logic [79:0] s_axis_tdata,
	// [0] action
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] noise_value
	output logic [15:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [23:0]        coord_scale_q;
	gn2d_item_t         in_item, q_item;
	logic               q_valid, pop;
	logic signed [15:0] noise;

	// APB register: write on the access phase, reads return the scale (zero if paddr[2] is set)
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_COORD_SCALE[0]) ? {8'd0, coord_scale_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_scale_q <= COORD_SCALE_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == ADDR_COORD_SCALE[0]) begin
			coord_scale_q <= pwdata[23:0];
		end
	end

	// classify the beat: action selects load or evaluate
	assign in_item.ev = s_axis_tuser[0];
	assign in_item.px = $signed(s_axis_tdata[31:0]);
	assign in_item.py = $signed(s_axis_tdata[63:32]);
	assign in_item.idx = s_axis_tdata[71:64];
	assign in_item.val = s_axis_tdata[79:72];

	gn2d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop)
	);

	gn2d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.pop         (pop),
		.coord_scale (coord_scale_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (noise)
	);

	assign m_axis_tdata = noise;

endmodule

// File: hw/rtl/gn2d_front.sv
module gn2d_front import gn2d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  gn2d_item_t in_item,
	output logic       q_valid,
	output gn2d_item_t q_item,
	input  logic       pop
);

	gn2d_item_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;
	logic                push;

	assign in_ready = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign q_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= in_item;
	end

endmodule

// File: hw/rtl/gn2d_back.sv
`include "gradient_noise_2d_unit_defines.svh"
module gn2d_back import gn2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  gn2d_item_t         q_item,
	output logic               pop,
	input  logic [23:0]        coord_scale,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_data
);

	logic en;
	assign en = !out_valid || out_ready;
	assign pop = en && q_valid;

	// four copies of the permutation table, each read at two addresses
	logic [7:0] perm_a [TABLE_SIZE];
	logic [7:0] perm_b [TABLE_SIZE];
	logic [7:0] perm_c [TABLE_SIZE];
	logic [7:0] perm_d [TABLE_SIZE];

	// s1
	logic                 v_s1, ev_s1;
	logic [IDX_W-1:0]     widx_s1, x0_s1, y0_s1;
	logic [7:0]           wval_s1;
	logic [15:0]          fx_s1, fy_s1;
	logic signed [56:0]   prodx, prody;
	// s2
	logic                 v_s2;
	logic [7:0]           pxa_s2, pxb_s2, pya_s2, pyb_s2;
	logic [15:0]          fx_s2, fy_s2;
	logic [31:0]          tsqx_s2, tsqy_s2;
	// s3
	logic                 v_s3;
	logic [7:0]           h0_s3, h1_s3, h2_s3, h3_s3;
	logic [15:0]          fx_s3, fy_s3;
	logic [19:0]          qx_s3, qy_s3;
	// s4
	logic                 v_s4;
	logic [31:0]          g0_s4, g1_s4, g2_s4, g3_s4;
	logic [15:0]          fx_s4, fy_s4;
	logic [19:0]          fax_s4, fay_s4;
	// s5
	logic                 v_s5;
	logic signed [33:0]   d0_s5, d1_s5, d2_s5, d3_s5;
	logic [15:0]          fx_s5, fy_s5;
	logic [19:0]          fbx_s5, fby_s5;
	// s6
	logic                 v_s6;
	logic signed [33:0]   d0_s6, d1_s6, d2_s6, d3_s6;
	logic [19:0]          sx_s6, sy_s6;
	// s7
	logic                 v_s7;
	logic signed [34:0]   r0_s7, r1_s7;
	logic [19:0]          sy_s7;

	logic [IDX_W-1:0]     x1, y1;
	logic [IDX_W-1:0]     a0, a1, a2, a3;
	logic [35:0]          px2, py2;
	logic signed [16:0]   dxp, dxn, dyp, dyn;
	logic signed [34:0]   df0, df1;
	logic signed [35:0]   df2;
	logic signed [55:0]   m0, m1;
	logic signed [56:0]   m2;
	logic signed [36:0]   rr;
	logic signed [20:0]   rs;

	assign prodx = q_item.px * $signed({1'b0, coord_scale});
	assign prody = q_item.py * $signed({1'b0, coord_scale});

	assign x1 = x0_s1 + 1'b1;
	assign y1 = y0_s1 + 1'b1;

	assign a0 = IDX_W'(pxa_s2) + IDX_W'(pya_s2);
	assign a1 = IDX_W'(pxa_s2) + IDX_W'(pyb_s2);
	assign a2 = IDX_W'(pxb_s2) + IDX_W'(pya_s2);
	assign a3 = IDX_W'(pxb_s2) + IDX_W'(pyb_s2);

	// fade polynomial before the three Horner multiplies
	assign px2 = 36'(6 * {4'd0, tsqx_s2}) - 36'({20'd0, fx_s2} * 36'd15 << 16)
		+ (36'd10 << 32);
	assign py2 = 36'(6 * {4'd0, tsqy_s2}) - 36'({20'd0, fy_s2} * 36'd15 << 16)
		+ (36'd10 << 32);

	// corner offsets: frac, and frac - 1.0 as a 17-bit signed value
	assign dxp = $signed({1'b0, fx_s4});
	assign dxn = $signed({1'b1, fx_s4});
	assign dyp = $signed({1'b0, fy_s4});
	assign dyn = $signed({1'b1, fy_s4});

	assign df0 = 35'(d2_s6) - 35'(d0_s6);
	assign df1 = 35'(d3_s6) - 35'(d1_s6);
	assign m0 = df0 * $signed({1'b0, sx_s6});
	assign m1 = df1 * $signed({1'b0, sx_s6});
	assign df2 = 36'(r1_s7) - 36'(r0_s7);
	assign m2 = df2 * $signed({1'b0, sy_s7});
	assign rr = 37'(r0_s7) + 37'(m2 >>> 16) + 37'sd32768;
	assign rs = 21'(rr >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1 && ev_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			out_valid <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ev_s1 <= q_item.ev;
			widx_s1 <= IDX_W'(q_item.idx);
			wval_s1 <= q_item.val;
			x0_s1 <= prodx[32 +: IDX_W];
			y0_s1 <= prody[32 +: IDX_W];
			fx_s1 <= prodx[31:16];
			fy_s1 <= prody[31:16];

			pxa_s2 <= perm_a[x0_s1];
			pxb_s2 <= perm_a[x1];
			pya_s2 <= perm_b[y0_s1];
			pyb_s2 <= perm_b[y1];
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			tsqx_s2 <= fx_s1 * fx_s1;
			tsqy_s2 <= fy_s1 * fy_s1;

			h0_s3 <= perm_c[a0];
			h1_s3 <= perm_c[a1];
			h2_s3 <= perm_d[a2];
			h3_s3 <= perm_d[a3];
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			qx_s3 <= px2[35:16];
			qy_s3 <= py2[35:16];

			g0_s4 <= GRAD_ROM[IDX_W'(h0_s3)];
			g1_s4 <= GRAD_ROM[IDX_W'(h1_s3)];
			g2_s4 <= GRAD_ROM[IDX_W'(h2_s3)];
			g3_s4 <= GRAD_ROM[IDX_W'(h3_s3)];
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			fax_s4 <= 20'((36'(fx_s3) * 36'(qx_s3)) >> 16);
			fay_s4 <= 20'((36'(fy_s3) * 36'(qy_s3)) >> 16);

			d0_s5 <= 34'(dxp) * 34'($signed(g0_s4[15:0]))
				+ 34'(dyp) * 34'($signed(g0_s4[31:16]));
			d1_s5 <= 34'(dxp) * 34'($signed(g1_s4[15:0]))
				+ 34'(dyn) * 34'($signed(g1_s4[31:16]));
			d2_s5 <= 34'(dxn) * 34'($signed(g2_s4[15:0]))
				+ 34'(dyp) * 34'($signed(g2_s4[31:16]));
			d3_s5 <= 34'(dxn) * 34'($signed(g3_s4[15:0]))
				+ 34'(dyn) * 34'($signed(g3_s4[31:16]));
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			fbx_s5 <= 20'((36'(fx_s4) * 36'(fax_s4)) >> 16);
			fby_s5 <= 20'((36'(fy_s4) * 36'(fay_s4)) >> 16);

			d0_s6 <= d0_s5;
			d1_s6 <= d1_s5;
			d2_s6 <= d2_s5;
			d3_s6 <= d3_s5;
			sx_s6 <= 20'((36'(fx_s5) * 36'(fbx_s5)) >> 16);
			sy_s6 <= 20'((36'(fy_s5) * 36'(fby_s5)) >> 16);

			r0_s7 <= 35'(d0_s6) + 35'(m0 >>> 16);
			r1_s7 <= 35'(d1_s6) + 35'(m1 >>> 16);
			sy_s7 <= sy_s6;

			if (rs > 21'sd32767) out_data <= 16'sh7FFF;
			else if (rs < -21'sd32768) out_data <= -16'sh8000;
			else out_data <= 16'(rs);
		end
	end

	// loads write all copies at the stage where the first lookup reads
	always_ff @(posedge clk) begin
		if (en && v_s1 && !ev_s1) begin
			perm_a[widx_s1] <= wval_s1;
			perm_b[widx_s1] <= wval_s1;
			perm_c[widx_s1] <= wval_s1;
			perm_d[widx_s1] <= wval_s1;
		end
	end

	`GN2D_ASSERT_NXT(a_stall_holds_s1, !en, $stable(v_s1) && $stable(v_s7))
	`GN2D_ASSERT_NXT(a_eval_advances, en && v_s1 && ev_s1, v_s2)
	`GN2D_ASSERT_NXT(a_load_retires, en && v_s1 && !ev_s1, !v_s2)

endmodule
